>>> rtl/m2ff_pkg.sv
// -----------------------------------------------------------------------------
// m2ff_pkg
// Shared codes for the 2D Maxwell face flux unit: flux modes, register
// indexes and the configuration bus geometry.
// -----------------------------------------------------------------------------
package m2ff_pkg;

   // Configuration bus geometry: one register, word aligned
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   // Register index as decoded from the word address bit
   localparam logic [0:0] REG_FLUX_MODE = 1'b0;

   typedef enum logic {
      FLUX_CENTERED = 1'b0,
      FLUX_UPWIND   = 1'b1
   } flux_mode_type;

   localparam flux_mode_type FLUX_MODE_RESET = FLUX_UPWIND;

endpackage

>>> rtl/m2ff_isqrt.sv
// -----------------------------------------------------------------------------
// m2ff_isqrt
// Pipelined integer square root, one result bit per stage, rounded to
// nearest in a final stage, one operand a cycle.
// -----------------------------------------------------------------------------
module m2ff_isqrt #(
   parameter int RootWidth = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [2*RootWidth-1:0]   radicand,
   output logic                     out_valid,
   output logic [RootWidth-1:0]     root
);
   localparam int RadW = 2 * RootWidth;
   localparam int RemW = RootWidth + 2;

   logic [RemW-1:0]      rem_src [RootWidth];
   logic [RootWidth-1:0] q_src   [RootWidth];
   logic [RadW-1:0]      rad_src [RootWidth];
   logic                 vld_src [RootWidth];

   logic [RemW-1:0]      rem_ff  [RootWidth];
   logic [RootWidth-1:0] q_ff    [RootWidth];
   logic [RadW-1:0]      rad_ff  [RootWidth];
   logic                 vld_ff  [RootWidth];

   logic [RootWidth-1:0] root_ff;
   logic [RootWidth-1:0] root_in;
   logic                 out_valid_ff;

   genvar k;
   generate
      for (k = 0; k < RootWidth; k++) begin : g_stage
         logic [RemW-1:0]      rem_sh;
         logic [RemW-1:0]      trial;
         logic                 fits;
         logic [RemW-1:0]      rem_in;
         logic [RootWidth-1:0] q_in;

         if (k == 0) begin : g_first
            assign rem_src[k] = '0;
            assign q_src[k]   = '0;
            assign rad_src[k] = radicand;
            assign vld_src[k] = in_valid;
         end else begin : g_next
            assign rem_src[k] = rem_ff[k-1];
            assign q_src[k]   = q_ff[k-1];
            assign rad_src[k] = rad_ff[k-1];
            assign vld_src[k] = vld_ff[k-1];
         end

         // bring down the next pair of radicand bits and try the new root bit
         assign rem_sh = {rem_src[k][RemW-3:0], rad_src[k][RadW-1:RadW-2]};
         assign trial  = {q_src[k], 2'b01};
         assign fits   = (rem_sh >= trial);
         assign rem_in = fits ? (rem_sh - trial) : rem_sh;
         assign q_in   = {q_src[k][RootWidth-2:0], fits};

         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in;
            q_ff[k]   <= q_in;
            rad_ff[k] <= {rad_src[k][RadW-3:0], 2'b00};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else begin
               vld_ff[k] <= vld_src[k];
            end
         end
      end
   endgenerate

   // round to nearest: step up when the remainder exceeds the floor root
   assign root_in = (rem_ff[RootWidth-1] > {2'b00, q_ff[RootWidth-1]})
                  ? q_ff[RootWidth-1] + 1'b1 : q_ff[RootWidth-1];

   always_ff @(posedge clock) begin
      root_ff <= root_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= vld_ff[RootWidth-1];
      end
   end

   assign root      = root_ff;
   assign out_valid = out_valid_ff;

endmodule

>>> rtl/m2ff_delay.sv
// -----------------------------------------------------------------------------
// m2ff_delay
// Fixed-length register line that keeps side data in step with the root
// pipeline.
// -----------------------------------------------------------------------------
module m2ff_delay #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic [Width-1:0] din,
   output logic [Width-1:0] dout
);
   logic [Width-1:0] tap_ff [Depth];

   always_ff @(posedge clock) begin
      tap_ff[0] <= din;
      for (int i = 1; i < Depth; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign dout = tap_ff[Depth-1];

endmodule

>>> rtl/m2ff_flux_lane.sv
// -----------------------------------------------------------------------------
// m2ff_flux_lane
// Tail of one flux component: jump penalty product (upwind mode only),
// accumulate, then round to nearest (ties up) and saturate. Three register stages.
// -----------------------------------------------------------------------------
module m2ff_flux_lane #(
   parameter int StateWidth  = 24,
   parameter int NormalWidth = 16
) (
   input  logic                                      clock,
   input  m2ff_pkg::flux_mode_type                   mode,
   input  logic signed [NormalWidth+StateWidth+1:0]  partial,
   input  logic signed [StateWidth:0]                jump,
   input  logic        [NormalWidth-1:0]             root,
   output logic signed [StateWidth-1:0]              flux
);
   import m2ff_pkg::*;

   localparam int PartW = NormalWidth + StateWidth + 2;
   localparam int AccW  = PartW + 1;
   localparam int Shift = NormalWidth - 1;
   localparam logic signed [AccW-1:0] Half = AccW'(1) <<< (Shift - 1);
   localparam logic signed [StateWidth-1:0] MaxV = {1'b0, {(StateWidth-1){1'b1}}};
   localparam logic signed [StateWidth-1:0] MinV = {1'b1, {(StateWidth-1){1'b0}}};

   logic signed [PartW-1:0]      pen_ff;
   logic signed [PartW-1:0]      part_ff;
   logic signed [AccW-1:0]       acc_ff;
   logic signed [AccW-1:0]       rounded;
   logic signed [AccW-1:0]       shifted;
   logic                         over_pos;
   logic                         over_neg;
   logic signed [StateWidth-1:0] flux_in;
   logic signed [StateWidth-1:0] flux_ff;

   always_ff @(posedge clock) begin
      if (mode == FLUX_UPWIND) begin
         pen_ff <= PartW'(signed'({1'b0, root})) * PartW'(jump);
      end else begin
         pen_ff <= '0;
      end
      part_ff <= partial;
      acc_ff  <= AccW'(part_ff) - AccW'(pen_ff);
      flux_ff <= flux_in;
   end

   assign rounded  = acc_ff + Half;
   assign shifted  = rounded >>> Shift;
   assign over_pos = !shifted[AccW-1] && (|shifted[AccW-1:StateWidth-1]);
   assign over_neg = shifted[AccW-1] && !(&shifted[AccW-1:StateWidth-1]);

   always_comb begin
      if (over_pos) begin
         flux_in = MaxV;
      end else if (over_neg) begin
         flux_in = MinV;
      end else begin
         flux_in = shifted[StateWidth-1:0];
      end
   end

   assign flux = flux_ff;

endmodule

>>> rtl/maxwell_2d_face_flux_unit.sv
// -----------------------------------------------------------------------------
// maxwell_2d_face_flux_unit
// Upwind or centred numerical face flux for 2D Maxwell with divergence
// cleaning, streaming one face per clock.
// -----------------------------------------------------------------------------
// The unit takes one face transfer on every clock at which start is high;
// busy stays low, so faces may follow one another with no gap. Each face
// gives exactly one result, shown on the rsp_ ports for a single cycle with
// rsp_valid high. The latency is set by the normal-length square root,
// which resolves one root bit per pipeline stage; the receiver must take
// every result in the cycle it appears. flux_mode is written over the APB
// port at byte address 0 and applies to faces started after the write.
// -----------------------------------------------------------------------------
module maxwell_2d_face_flux_unit #(
   parameter int STATE_WIDTH  = 24,
   parameter int NORMAL_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // face transfer
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [STATE_WIDTH-1:0]           req_left_ex,
   input  logic signed [STATE_WIDTH-1:0]           req_left_ey,
   input  logic signed [STATE_WIDTH-1:0]           req_left_hz,
   input  logic signed [STATE_WIDTH-1:0]           req_left_lambda,
   input  logic signed [STATE_WIDTH-1:0]           req_right_ex,
   input  logic signed [STATE_WIDTH-1:0]           req_right_ey,
   input  logic signed [STATE_WIDTH-1:0]           req_right_hz,
   input  logic signed [STATE_WIDTH-1:0]           req_right_lambda,
   input  logic signed [NORMAL_WIDTH-1:0]          req_normal_x,
   input  logic signed [NORMAL_WIDTH-1:0]          req_normal_y,
   // result transfer
   output logic                                    rsp_valid,
   output logic signed [STATE_WIDTH-1:0]           rsp_flux_ex,
   output logic signed [STATE_WIDTH-1:0]           rsp_flux_ey,
   output logic signed [STATE_WIDTH-1:0]           rsp_flux_hz,
   output logic signed [STATE_WIDTH-1:0]           rsp_flux_lambda,
   // configuration
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [m2ff_pkg::CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [m2ff_pkg::CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [m2ff_pkg::CSR_DATA_WIDTH-1:0]     prdata,
   output logic                                    pready
);
   import m2ff_pkg::*;

   localparam int SW      = STATE_WIDTH + 1;                  // sums and jumps
   localparam int SqW     = 2 * NORMAL_WIDTH;                 // squares, radicand
   localparam int ProdW   = NORMAL_WIDTH + STATE_WIDTH + 1;   // normal times sum
   localparam int PartW   = ProdW + 1;                        // two products
   localparam int LaneW   = PartW + SW;
   localparam int DlyW    = 4 * LaneW + 1;
   localparam int Latency = NORMAL_WIDTH + 6;

   // ---------------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------------
   flux_mode_type flux_mode_ff;
   logic          csr_write_en;

   assign pready       = 1'b1;
   assign csr_write_en = psel && penable && pwrite && pready &&
                         (paddr[CSR_ADDR_WIDTH-1] == REG_FLUX_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         flux_mode_ff <= FLUX_MODE_RESET;
      end else if (csr_write_en) begin
         flux_mode_ff <= flux_mode_type'(pwdata[0]);
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_WIDTH-1] == REG_FLUX_MODE) begin
         prdata[0] = flux_mode_ff;
      end
   end

   // the pipeline never holds off a face
   assign busy = 1'b0;

   // ---------------------------------------------------------------------------
   // Stage A: sums, jumps and squares of the normal
   // Component order: ex, ey, hz, lambda
   // ---------------------------------------------------------------------------
   logic signed [STATE_WIDTH-1:0]  left_s  [4];
   logic signed [STATE_WIDTH-1:0]  right_s [4];
   logic signed [SW-1:0]           sum_a_ff [4];
   logic signed [SW-1:0]           dif_a_ff [4];
   logic signed [NORMAL_WIDTH-1:0] nx_a_ff;
   logic signed [NORMAL_WIDTH-1:0] ny_a_ff;
   logic signed [SqW-1:0]          sqx_a_ff;
   logic signed [SqW-1:0]          sqy_a_ff;
   flux_mode_type                  mode_a_ff;
   logic                           valid_a_ff;

   assign left_s[0]  = req_left_ex;
   assign left_s[1]  = req_left_ey;
   assign left_s[2]  = req_left_hz;
   assign left_s[3]  = req_left_lambda;
   assign right_s[0] = req_right_ex;
   assign right_s[1] = req_right_ey;
   assign right_s[2] = req_right_hz;
   assign right_s[3] = req_right_lambda;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         sum_a_ff[i] <= SW'(right_s[i]) + SW'(left_s[i]);
         dif_a_ff[i] <= SW'(right_s[i]) - SW'(left_s[i]);
      end
      nx_a_ff   <= req_normal_x;
      ny_a_ff   <= req_normal_y;
      sqx_a_ff  <= SqW'(req_normal_x) * SqW'(req_normal_x);
      sqy_a_ff  <= SqW'(req_normal_y) * SqW'(req_normal_y);
      mode_a_ff <= flux_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= start && !busy;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage B: radicand and the eight normal-by-sum products
   // ---------------------------------------------------------------------------
   logic [SqW-1:0]           rad_b_ff;
   logic signed [ProdW-1:0]  prod_b_ff [8];
   logic signed [SW-1:0]     dif_b_ff  [4];
   flux_mode_type            mode_b_ff;
   logic                     valid_b_ff;

   always_ff @(posedge clock) begin
      rad_b_ff     <= $unsigned(sqx_a_ff) + $unsigned(sqy_a_ff);
      // ex: -ny*s_hz + nx*s_lambda
      prod_b_ff[0] <= ProdW'(ny_a_ff) * ProdW'(sum_a_ff[2]);
      prod_b_ff[1] <= ProdW'(nx_a_ff) * ProdW'(sum_a_ff[3]);
      // ey: nx*s_hz + ny*s_lambda
      prod_b_ff[2] <= ProdW'(nx_a_ff) * ProdW'(sum_a_ff[2]);
      prod_b_ff[3] <= ProdW'(ny_a_ff) * ProdW'(sum_a_ff[3]);
      // hz: -ny*s_ex + nx*s_ey
      prod_b_ff[4] <= ProdW'(ny_a_ff) * ProdW'(sum_a_ff[0]);
      prod_b_ff[5] <= ProdW'(nx_a_ff) * ProdW'(sum_a_ff[1]);
      // lambda: nx*s_ex + ny*s_ey
      prod_b_ff[6] <= ProdW'(nx_a_ff) * ProdW'(sum_a_ff[0]);
      prod_b_ff[7] <= ProdW'(ny_a_ff) * ProdW'(sum_a_ff[1]);
      for (int i = 0; i < 4; i++) begin
         dif_b_ff[i] <= dif_a_ff[i];
      end
      mode_b_ff <= mode_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage C: combine product pairs; the root pipeline starts alongside
   // ---------------------------------------------------------------------------
   logic signed [PartW-1:0] part_c_ff [4];
   logic signed [SW-1:0]    dif_c_ff  [4];
   flux_mode_type           mode_c_ff;

   always_ff @(posedge clock) begin
      part_c_ff[0] <= PartW'(prod_b_ff[1]) - PartW'(prod_b_ff[0]);
      part_c_ff[1] <= PartW'(prod_b_ff[3]) + PartW'(prod_b_ff[2]);
      part_c_ff[2] <= PartW'(prod_b_ff[5]) - PartW'(prod_b_ff[4]);
      part_c_ff[3] <= PartW'(prod_b_ff[7]) + PartW'(prod_b_ff[6]);
      for (int i = 0; i < 4; i++) begin
         dif_c_ff[i] <= dif_b_ff[i];
      end
      mode_c_ff <= mode_b_ff;
   end

   logic [NORMAL_WIDTH-1:0] root;
   logic                    root_valid;

   m2ff_isqrt #(
      .RootWidth (NORMAL_WIDTH)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_b_ff),
      .radicand  (rad_b_ff),
      .out_valid (root_valid),
      .root      (root)
   );

   // hold partial sums, jumps and mode until the root arrives
   logic [DlyW-1:0] dly_in;
   logic [DlyW-1:0] dly_out;

   always_comb begin
      dly_in        = '0;
      dly_in[DlyW-1] = mode_c_ff;
      for (int i = 0; i < 4; i++) begin
         dly_in[i*LaneW +: LaneW] = {part_c_ff[i], dif_c_ff[i]};
      end
   end

   m2ff_delay #(
      .Width (DlyW),
      .Depth (NORMAL_WIDTH)
   ) u_delay (
      .clock (clock),
      .din   (dly_in),
      .dout  (dly_out)
   );

   // ---------------------------------------------------------------------------
   // Lanes: penalty, accumulate, round and saturate
   // ---------------------------------------------------------------------------
   flux_mode_type                 mode_d;
   logic signed [STATE_WIDTH-1:0] flux_out [4];

   assign mode_d = flux_mode_type'(dly_out[DlyW-1]);

   genvar g;
   generate
      for (g = 0; g < 4; g++) begin : g_lane
         m2ff_flux_lane #(
            .StateWidth  (STATE_WIDTH),
            .NormalWidth (NORMAL_WIDTH)
         ) u_lane (
            .clock   (clock),
            .mode    (mode_d),
            .partial (signed'(dly_out[g*LaneW+SW +: PartW])),
            .jump    (signed'(dly_out[g*LaneW +: SW])),
            .root    (root),
            .flux    (flux_out[g])
         );
      end
   endgenerate

   // advance the valid bit through the three lane stages
   logic [2:0] valid_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_t_ff <= '0;
      end else begin
         valid_t_ff <= {valid_t_ff[1:0], root_valid};
      end
   end

   assign rsp_valid       = valid_t_ff[2];
   assign rsp_flux_ex     = flux_out[0];
   assign rsp_flux_ey     = flux_out[1];
   assign rsp_flux_hz     = flux_out[2];
   assign rsp_flux_lambda = flux_out[3];

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_result_has_face: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency))
      else $error("result without a face transfer at the pipeline latency");

   a_root_in_step: assert property (@(posedge clock) disable iff (reset)
      root_valid |-> $past(valid_b_ff, NORMAL_WIDTH + 1))
      else $error("root pipeline out of step with side data");

   a_mode_by_write: assert property (@(posedge clock) disable iff (reset)
      (!$stable(flux_mode_ff) && !$past(reset)) |-> $past(csr_write_en))
      else $error("flux mode changed without a register write");

endmodule
